// ===== hw/rtl/acsc_pkg.sv =====
// Shared types, register indexes, reset values and the quadrature decode table
// for the alarm clock setting controller.
// Depends on nothing; used by alarm_clock_setting_controller_unit.
package acsc_pkg;

    // Field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned FREQ_W   = 12;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned LONG_W   = 16;
    localparam int unsigned DEB_W    = 10;
    localparam int unsigned PART_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 3'd4;

    // Configuration reset values
    localparam logic [STEP_W-1:0] FREQ_STEP_RST     = 10'd100;
    localparam logic [FREQ_W-1:0] FREQ_MIN_RST      = 12'd200;
    localparam logic [FREQ_W-1:0] FREQ_MAX_RST      = 12'd4000;
    localparam logic [LONG_W-1:0] LONG_PRESS_MS_RST = 16'd2000;
    localparam logic [DEB_W-1:0]  DEBOUNCE_MS_RST   = 10'd50;

    // State reset values
    localparam logic [HOUR_W-1:0]   HOUR_RST = 5'd12;
    localparam logic [FREQ_W-1:0]   FREQ_RST = 12'd1000;

    // Wrap limits of the alarm time
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;

    // Edited part codes
    typedef logic [PART_W-1:0] part_t;
    localparam part_t PART_NONE   = 2'd0;
    localparam part_t PART_HOUR   = 2'd1;
    localparam part_t PART_MINUTE = 2'd2;

    // Encoder step direction
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    // Decode {previous code, current code} into a step direction
    function automatic dir_t quad_dir(input logic [3:0] trans);
        dir_t d;
        unique case (trans) inside
            4'b1101, 4'b0100, 4'b0010, 4'b1011: d = DIR_UP;
            4'b1110, 4'b0111, 4'b0001, 4'b1000: d = DIR_DOWN;
            default:                            d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/alarm_clock_setting_controller_unit.sv =====
// Alarm clock setting controller: button, encoder and alarm-match handling.
// Depends on acsc_pkg for widths, codes, reset values and the quadrature table.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  in      | in_valid / in_stall       | now_ms, button_level, enc_a, enc_b,
//          |                           | clock_hour, clock_minute
//  out     | out_valid / out_stall     | setting_mode, edited_part, alarm_hour,
//          |                           | alarm_minute, tone_freq, buzzer_on
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data (ready is always high)
//
// One tick per cycle while the result is not stalled: a tick is captured in the
// input register, then the state update loads the result register from it. The
// state registers are the result register. Reset loads the default configuration
// and state; no clearing pass. A stalled result holds; the input register still
// takes one tick behind it.
module alarm_clock_setting_controller_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [acsc_pkg::TIME_W-1:0]         now_ms,
    input  logic                                button_level,
    input  logic                                enc_a,
    input  logic                                enc_b,
    input  logic [acsc_pkg::HOUR_W-1:0]         clock_hour,
    input  logic [acsc_pkg::MINUTE_W-1:0]       clock_minute,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                setting_mode,
    output logic [acsc_pkg::PART_W-1:0]         edited_part,
    output logic [acsc_pkg::HOUR_W-1:0]         alarm_hour,
    output logic [acsc_pkg::MINUTE_W-1:0]       alarm_minute,
    output logic [acsc_pkg::FREQ_W-1:0]         tone_freq,
    output logic                                buzzer_on,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [acsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);

    // Configuration registers
    logic [acsc_pkg::STEP_W-1:0]  freq_step_reg;
    logic [acsc_pkg::FREQ_W-1:0]  freq_min_reg;
    logic [acsc_pkg::FREQ_W-1:0]  freq_max_reg;
    logic [acsc_pkg::LONG_W-1:0]  long_press_reg;
    logic [acsc_pkg::DEB_W-1:0]   debounce_reg;

    // Input register
    logic                           s1_valid_reg;
    logic [acsc_pkg::TIME_W-1:0]    s1_now_reg;
    logic                           s1_btn_reg;
    logic [1:0]                     s1_code_reg;
    logic [acsc_pkg::HOUR_W-1:0]    s1_hour_reg;
    logic [acsc_pkg::MINUTE_W-1:0]  s1_minute_reg;

    // Controller state, doubling as the result register
    logic                           out_valid_reg;
    logic                           mode_reg, mode_next;
    acsc_pkg::part_t                part_reg, part_next;
    logic [acsc_pkg::HOUR_W-1:0]    hour_reg, hour_next;
    logic [acsc_pkg::MINUTE_W-1:0]  minute_reg, minute_next;
    logic [acsc_pkg::FREQ_W-1:0]    freq_reg, freq_next;
    logic [1:0]                     prev_quad_reg;
    logic                           prev_btn_reg;
    logic                           pending_reg, pending_next;
    logic [acsc_pkg::TIME_W-1:0]    press_start_reg, press_start_next;
    logic [acsc_pkg::TIME_W-1:0]    last_handled_reg, last_handled_next;
    logic                           alarm_reg, alarm_next;
    logic                           fired_reg, fired_next;

    logic                           out_free;
    logic                           s1_advance;
    logic                           s1_load;

    acsc_pkg::dir_t                 dir;
    logic signed [acsc_pkg::FREQ_W+1:0] freq_sum;
    logic signed [acsc_pkg::FREQ_W+1:0] freq_lo;
    logic signed [acsc_pkg::FREQ_W+1:0] freq_hi;
    logic [acsc_pkg::TIME_W-1:0]    since_handled;
    logic [acsc_pkg::TIME_W-1:0]    press_len;
    logic                           event_go;

    // Pipeline flow control
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign s1_load    = !s1_valid_reg || out_free;
    assign in_stall   = !s1_load;
    assign cfg_ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg  <= acsc_pkg::FREQ_STEP_RST;
            freq_min_reg   <= acsc_pkg::FREQ_MIN_RST;
            freq_max_reg   <= acsc_pkg::FREQ_MAX_RST;
            long_press_reg <= acsc_pkg::LONG_PRESS_MS_RST;
            debounce_reg   <= acsc_pkg::DEBOUNCE_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                acsc_pkg::CFG_FREQ_STEP:     freq_step_reg  <= cfg_data[acsc_pkg::STEP_W-1:0];
                acsc_pkg::CFG_FREQ_MIN:      freq_min_reg   <= cfg_data[acsc_pkg::FREQ_W-1:0];
                acsc_pkg::CFG_FREQ_MAX:      freq_max_reg   <= cfg_data[acsc_pkg::FREQ_W-1:0];
                acsc_pkg::CFG_LONG_PRESS_MS: long_press_reg <= cfg_data[acsc_pkg::LONG_W-1:0];
                acsc_pkg::CFG_DEBOUNCE_MS:   debounce_reg   <= cfg_data[acsc_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: capture a tick whenever the slot frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_now_reg    <= now_ms;
            s1_btn_reg    <= button_level;
            s1_code_reg   <= {enc_a, enc_b};
            s1_hour_reg   <= clock_hour;
            s1_minute_reg <= clock_minute;
        end
    end

    // Tick update
    always_comb
    begin
        // Button edges: a press records the time, a release arms the event
        press_start_next = press_start_reg;
        pending_next     = pending_reg;
        if (!s1_btn_reg && prev_btn_reg)
        begin
            press_start_next = s1_now_reg;
        end
        else if (s1_btn_reg && !prev_btn_reg)
        begin
            pending_next = 1'b1;
        end

        // Encoder: frequency in normal mode, alarm time in set mode
        dir      = acsc_pkg::quad_dir({prev_quad_reg, s1_code_reg});
        freq_lo  = $signed({2'b00, freq_min_reg});
        freq_hi  = $signed({2'b00, freq_max_reg});
        freq_sum = $signed({2'b00, freq_reg});
        if (dir == acsc_pkg::DIR_UP)
        begin
            freq_sum = freq_sum + $signed({4'b0000, freq_step_reg});
        end
        else if (dir == acsc_pkg::DIR_DOWN)
        begin
            freq_sum = freq_sum - $signed({4'b0000, freq_step_reg});
        end

        freq_next   = freq_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        if (!mode_reg)
        begin
            if (freq_sum < freq_lo)
            begin
                freq_next = freq_min_reg;
            end
            else if (freq_sum > freq_hi)
            begin
                freq_next = freq_max_reg;
            end
            else
            begin
                freq_next = freq_sum[acsc_pkg::FREQ_W-1:0];
            end
        end
        else if (part_reg == acsc_pkg::PART_HOUR)
        begin
            if (dir == acsc_pkg::DIR_UP)
            begin
                hour_next = (hour_reg == acsc_pkg::HOUR_LAST) ? '0 : hour_reg + 1'b1;
            end
            else if (dir == acsc_pkg::DIR_DOWN)
            begin
                hour_next = (hour_reg == '0) ? acsc_pkg::HOUR_LAST : hour_reg - 1'b1;
            end
        end
        else if (part_reg == acsc_pkg::PART_MINUTE)
        begin
            if (dir == acsc_pkg::DIR_UP)
            begin
                minute_next = (minute_reg == acsc_pkg::MINUTE_LAST) ? '0 : minute_reg + 1'b1;
            end
            else if (dir == acsc_pkg::DIR_DOWN)
            begin
                minute_next = (minute_reg == '0) ? acsc_pkg::MINUTE_LAST : minute_reg - 1'b1;
            end
        end

        // Pending button event, taken once the debounce window has passed
        since_handled     = s1_now_reg - last_handled_reg;
        press_len         = s1_now_reg - press_start_next;
        event_go          = pending_next &&
                            (since_handled > {{(acsc_pkg::TIME_W-acsc_pkg::DEB_W){1'b0}},
                                              debounce_reg});
        mode_next         = mode_reg;
        part_next         = part_reg;
        alarm_next        = alarm_reg;
        last_handled_next = last_handled_reg;
        if (event_go)
        begin
            pending_next      = 1'b0;
            last_handled_next = s1_now_reg;
            if (press_len >= {{(acsc_pkg::TIME_W-acsc_pkg::LONG_W){1'b0}}, long_press_reg})
            begin
                if (!mode_reg && !alarm_reg)
                begin
                    mode_next = 1'b1;
                    part_next = acsc_pkg::PART_HOUR;
                end
            end
            else if (mode_reg)
            begin
                if (part_reg == acsc_pkg::PART_HOUR)
                begin
                    part_next = acsc_pkg::PART_MINUTE;
                end
                else if (part_reg == acsc_pkg::PART_MINUTE)
                begin
                    part_next = acsc_pkg::PART_NONE;
                    mode_next = 1'b0;
                end
            end
            else
            begin
                alarm_next = 1'b0;
            end
        end

        // Alarm match, once per minute
        fired_next = fired_reg;
        if (!mode_next && !fired_reg && s1_hour_reg == hour_next &&
            s1_minute_reg == minute_next)
        begin
            alarm_next = 1'b1;
            fired_next = 1'b1;
        end
        if (s1_minute_reg != minute_next)
        begin
            fired_next = 1'b0;
        end
    end

    // Commit the tick into state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            mode_reg         <= 1'b0;
            part_reg         <= acsc_pkg::PART_NONE;
            hour_reg         <= acsc_pkg::HOUR_RST;
            minute_reg       <= '0;
            freq_reg         <= acsc_pkg::FREQ_RST;
            prev_quad_reg    <= '0;
            prev_btn_reg     <= 1'b1;
            pending_reg      <= 1'b0;
            press_start_reg  <= '0;
            last_handled_reg <= '0;
            alarm_reg        <= 1'b0;
            fired_reg        <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_advance)
            begin
                mode_reg         <= mode_next;
                part_reg         <= part_next;
                hour_reg         <= hour_next;
                minute_reg       <= minute_next;
                freq_reg         <= freq_next;
                prev_quad_reg    <= s1_code_reg;
                prev_btn_reg     <= s1_btn_reg;
                pending_reg      <= pending_next;
                press_start_reg  <= press_start_next;
                last_handled_reg <= last_handled_next;
                alarm_reg        <= alarm_next;
                fired_reg        <= fired_next;
            end
        end
    end

    // Drive the result
    assign out_valid    = out_valid_reg;
    assign setting_mode = mode_reg;
    assign edited_part  = part_reg;
    assign alarm_hour   = hour_reg;
    assign alarm_minute = minute_reg;
    assign tone_freq    = freq_reg;
    assign buzzer_on    = alarm_reg;

    // Set mode and an edited part go together
    a_mode_part: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == (part_reg != acsc_pkg::PART_NONE))
        else $error("setting mode and edited part disagree");

    // Alarm time stays in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        hour_reg <= acsc_pkg::HOUR_LAST && minute_reg <= acsc_pkg::MINUTE_LAST)
        else $error("alarm time out of range");

    // Result state moves only when a tick is committed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable({mode_reg, part_reg, hour_reg, minute_reg,
                                 freq_reg, alarm_reg}))
        else $error("result changed without a committed tick");

endmodule

// ===== test/alarm_clock_setting_controller_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for alarm_clock_setting_controller_unit: directed and random ticks,
// scoreboard predictor of mode, alarm time, tone and buzzer. Depends on acsc_pkg and the RTL.

// One loop tick as offered to the block
typedef struct packed {
    logic [acsc_pkg::TIME_W-1:0]   now_ms;
    logic                          button_level;
    logic                          enc_a;
    logic                          enc_b;
    logic [acsc_pkg::HOUR_W-1:0]   clock_hour;
    logic [acsc_pkg::MINUTE_W-1:0] clock_minute;
} tick_t;

// Controller outputs after one tick
typedef struct packed {
    logic                          setting_mode;
    acsc_pkg::part_t               edited_part;
    logic [acsc_pkg::HOUR_W-1:0]   alarm_hour;
    logic [acsc_pkg::MINUTE_W-1:0] alarm_minute;
    logic [acsc_pkg::FREQ_W-1:0]   tone_freq;
    logic                          buzzer_on;
} alarm_result_t;

// Position of a quadrature code along the clockwise cycle 00, 10, 11, 01
function automatic logic [1:0] gray_pos(input logic [1:0] code);
    case (code)
        2'b00:   return 2'd0;
        2'b10:   return 2'd1;
        2'b11:   return 2'd2;
        default: return 2'd3;
    endcase
endfunction

class alarm_scoreboard;
    // configuration
    logic [acsc_pkg::STEP_W-1:0] step_hz;
    logic [acsc_pkg::FREQ_W-1:0] min_hz;
    logic [acsc_pkg::FREQ_W-1:0] max_hz;
    logic [acsc_pkg::LONG_W-1:0] long_ms;
    logic [acsc_pkg::DEB_W-1:0]  debounce;
    // controller state
    logic                          set_mode;
    acsc_pkg::part_t               part;
    logic [acsc_pkg::HOUR_W-1:0]   hour;
    logic [acsc_pkg::MINUTE_W-1:0] minute;
    logic [acsc_pkg::FREQ_W-1:0]   freq;
    logic [1:0]                    last_code;
    logic                          last_btn;
    logic                          release_pend;
    logic [acsc_pkg::TIME_W-1:0]   press_t;
    logic [acsc_pkg::TIME_W-1:0]   handled_t;
    logic                          ringing;
    logic                          fired;

    alarm_result_t expected_q[$];
    int errors;
    int checked;
    int n_enter;
    int n_alarm;
    int n_silence;
    int n_ignored;

    function new();
        step_hz      = acsc_pkg::FREQ_STEP_RST;
        min_hz       = acsc_pkg::FREQ_MIN_RST;
        max_hz       = acsc_pkg::FREQ_MAX_RST;
        long_ms      = acsc_pkg::LONG_PRESS_MS_RST;
        debounce     = acsc_pkg::DEBOUNCE_MS_RST;
        set_mode     = 1'b0;
        part         = acsc_pkg::PART_NONE;
        hour         = acsc_pkg::HOUR_RST;
        minute       = '0;
        freq         = acsc_pkg::FREQ_RST;
        last_code    = 2'b00;
        last_btn     = 1'b1;
        release_pend = 1'b0;
        press_t      = '0;
        handled_t    = '0;
        ringing      = 1'b0;
        fired        = 1'b0;
        errors       = 0;
        checked      = 0;
        n_enter      = 0;
        n_alarm      = 0;
        n_silence    = 0;
        n_ignored    = 0;
    endfunction

    // Apply a register write accepted by the block
    function void write_reg(input logic [acsc_pkg::CFG_IDX_W-1:0] idx,
                            input logic [31:0] data);
        case (idx)
            acsc_pkg::CFG_FREQ_STEP:     step_hz  = data[acsc_pkg::STEP_W-1:0];
            acsc_pkg::CFG_FREQ_MIN:      min_hz   = data[acsc_pkg::FREQ_W-1:0];
            acsc_pkg::CFG_FREQ_MAX:      max_hz   = data[acsc_pkg::FREQ_W-1:0];
            acsc_pkg::CFG_LONG_PRESS_MS: long_ms  = data[acsc_pkg::LONG_W-1:0];
            acsc_pkg::CFG_DEBOUNCE_MS:   debounce = data[acsc_pkg::DEB_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the state by one accepted tick and queue the expected outputs
    function void note_tick(input tick_t t);
        logic [1:0]                  code;
        logic [1:0]                  delta;
        acsc_pkg::dir_t              dir;
        int                          f;
        logic [acsc_pkg::TIME_W-1:0] since;
        logic [acsc_pkg::TIME_W-1:0] held;
        alarm_result_t               r;

        // record press time, flag a release
        if (!t.button_level && last_btn)
            press_t = t.now_ms;
        else if (t.button_level && !last_btn)
            release_pend = 1'b1;
        last_btn = t.button_level;

        // decode the knob step from the move along the cycle
        code  = {t.enc_a, t.enc_b};
        delta = gray_pos(code) - gray_pos(last_code);
        if (delta == 2'd1)
            dir = acsc_pkg::DIR_UP;
        else if (delta == 2'd3)
            dir = acsc_pkg::DIR_DOWN;
        else
            dir = acsc_pkg::DIR_NONE;

        // step and clamp the tone, or step the alarm field being edited
        if (!set_mode) begin
            f = int'(freq);
            if (dir == acsc_pkg::DIR_UP)
                f = f + int'(step_hz);
            else if (dir == acsc_pkg::DIR_DOWN)
                f = f - int'(step_hz);
            if (f < int'(min_hz))
                f = int'(min_hz);
            else if (f > int'(max_hz))
                f = int'(max_hz);
            freq = f[acsc_pkg::FREQ_W-1:0];
        end else if (part == acsc_pkg::PART_HOUR) begin
            if (dir == acsc_pkg::DIR_UP)
                hour = (hour == acsc_pkg::HOUR_LAST) ? '0 : hour + 1'b1;
            else if (dir == acsc_pkg::DIR_DOWN)
                hour = (hour == 0) ? acsc_pkg::HOUR_LAST : hour - 1'b1;
        end else if (part == acsc_pkg::PART_MINUTE) begin
            if (dir == acsc_pkg::DIR_UP)
                minute = (minute == acsc_pkg::MINUTE_LAST) ? '0 : minute + 1'b1;
            else if (dir == acsc_pkg::DIR_DOWN)
                minute = (minute == 0) ? acsc_pkg::MINUTE_LAST : minute - 1'b1;
        end
        last_code = code;

        // take the pending button event once the debounce window has passed
        since = t.now_ms - handled_t;
        if (since > debounce && release_pend) begin
            held = t.now_ms - press_t;
            release_pend = 1'b0;
            if (held >= long_ms) begin
                if (!set_mode && !ringing) begin
                    set_mode = 1'b1;
                    part     = acsc_pkg::PART_HOUR;
                    n_enter++;
                end else begin
                    n_ignored++;
                end
            end else if (set_mode) begin
                if (part == acsc_pkg::PART_HOUR) begin
                    part = acsc_pkg::PART_MINUTE;
                end else if (part == acsc_pkg::PART_MINUTE) begin
                    part     = acsc_pkg::PART_NONE;
                    set_mode = 1'b0;
                end
            end else begin
                if (ringing)
                    n_silence++;
                ringing = 1'b0;
            end
            handled_t = t.now_ms;
        end

        // fire once per matching minute
        if (!set_mode && !fired && t.clock_hour == hour && t.clock_minute == minute) begin
            ringing = 1'b1;
            fired   = 1'b1;
            n_alarm++;
        end
        if (t.clock_minute != minute)
            fired = 1'b0;

        r.setting_mode = set_mode;
        r.edited_part  = part;
        r.alarm_hour   = hour;
        r.alarm_minute = minute;
        r.tone_freq    = freq;
        r.buzzer_on    = ringing;
        expected_q.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Check one result transfer against the oldest expectation
    function void check_result(input alarm_result_t got);
        alarm_result_t want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("setting_mode", 32'(want.setting_mode), 32'(got.setting_mode));
        compare_field("edited_part", 32'(want.edited_part), 32'(got.edited_part));
        compare_field("alarm_hour", 32'(want.alarm_hour), 32'(got.alarm_hour));
        compare_field("alarm_minute", 32'(want.alarm_minute), 32'(got.alarm_minute));
        compare_field("tone_freq", 32'(want.tone_freq), 32'(got.tone_freq));
        compare_field("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
    endfunction
endclass

module alarm_clock_setting_controller_unit_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 40;
    localparam int PHASE_TICKS = 230;
    // clockwise quadrature cycle, position i at bits [2i+1:2i]
    localparam logic [7:0] GRAY_SEQ = {2'b01, 2'b11, 2'b10, 2'b00};

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [acsc_pkg::TIME_W-1:0]     now_ms;
    logic                            button_level;
    logic                            enc_a;
    logic                            enc_b;
    logic [acsc_pkg::HOUR_W-1:0]     clock_hour;
    logic [acsc_pkg::MINUTE_W-1:0]   clock_minute;
    logic                            out_valid;
    logic                            out_stall;
    logic                            setting_mode;
    logic [acsc_pkg::PART_W-1:0]     edited_part;
    logic [acsc_pkg::HOUR_W-1:0]     alarm_hour;
    logic [acsc_pkg::MINUTE_W-1:0]   alarm_minute;
    logic [acsc_pkg::FREQ_W-1:0]     tone_freq;
    logic                            buzzer_on;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [acsc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]                     cfg_data;

    alarm_scoreboard       sb;
    alarm_result_t         seen_result;
    int                    cycle_count = 0;
    int unsigned           sent = 0;
    bit                    gaps_on = 1'b0;
    bit                    stall_bursts = 1'b0;
    bit                    hold_request = 1'b0;

    // stimulus state carried from tick to tick
    logic [acsc_pkg::TIME_W-1:0]     wall_ms;
    logic                            btn_now;
    logic [1:0]                      knob_code;
    logic [acsc_pkg::HOUR_W-1:0]     rtc_hour;
    logic [acsc_pkg::MINUTE_W-1:0]   rtc_minute;

    alarm_clock_setting_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .button_level (button_level),
        .enc_a        (enc_a),
        .enc_b        (enc_b),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .setting_mode (setting_mode),
        .edited_part  (edited_part),
        .alarm_hour   (alarm_hour),
        .alarm_minute (alarm_minute),
        .tone_freq    (tone_freq),
        .buzzer_on    (buzzer_on),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            seen_result.setting_mode = setting_mode;
            seen_result.edited_part  = edited_part;
            seen_result.alarm_hour   = alarm_hour;
            seen_result.alarm_minute = alarm_minute;
            seen_result.tone_freq    = tone_freq;
            seen_result.buzzer_on    = buzzer_on;
            sb.check_result(seen_result);
        end
    end

    // Drive the result stall: short random bursts, or one long hold on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer the current stimulus state as one tick and hold it until transferred
    task automatic send_tick();
        tick_t t;
        t.now_ms       = wall_ms;
        t.button_level = btn_now;
        t.enc_a        = knob_code[1];
        t.enc_b        = knob_code[0];
        t.clock_hour   = rtc_hour;
        t.clock_minute = rtc_minute;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        now_ms       <= t.now_ms;
        button_level <= t.button_level;
        enc_a        <= t.enc_a;
        enc_b        <= t.enc_b;
        clock_hour   <= t.clock_hour;
        clock_minute <= t.clock_minute;
        forever begin
            @(posedge clk);
            if (in_stall === 1'b0)
                break;
        end
        sb.note_tick(t);
        sent++;
        @(negedge clk);
    endtask

    task automatic tick(input int unsigned adv_ms);
        wall_ms = wall_ms + adv_ms;
        send_tick();
    endtask

    // Turn the knob by whole valid steps
    task automatic twist(input int n, input bit up);
        logic [1:0] pos;
        repeat (n) begin
            pos       = gray_pos(knob_code) + (up ? 2'd1 : 2'd3);
            knob_code = GRAY_SEQ[{pos, 1'b0} +: 2];
            tick($urandom_range(1, 40));
        end
    endtask

    task automatic knob_turn();
        bit up;
        up = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
                // jump two positions: not a valid step
                knob_code = ~knob_code;
                tick($urandom_range(1, 40));
            end else begin
                twist(1, up);
            end
        end
    endtask

    // Hold time around the long-press threshold of the current setting
    function automatic int unsigned pick_hold(input bit want_long);
        int unsigned lim;
        lim = sb.long_ms;
        if (want_long || lim == 0) begin
            case ($urandom_range(0, 2))
                0:       return lim;
                1:       return lim + 1;
                default: return lim + $urandom_range(1, 3000);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            return lim - 1;
        return $urandom_range(0, lim - 1);
    endfunction

    // Press, optionally hold over several ticks, release, optionally let time pass
    task automatic push_button(input int unsigned hold, input bit spread);
        int unsigned slice;
        btn_now = 1'b0;
        tick($urandom_range(1, 100));
        if (spread) begin
            repeat ($urandom_range(0, 3)) begin
                slice = $urandom_range(0, hold / 2);
                hold  = hold - slice;
                tick(slice);
            end
        end
        btn_now = 1'b1;
        tick(hold);
        if (spread)
            repeat ($urandom_range(0, 2)) tick($urandom_range(1, sb.debounce + 20));
    endtask

    // Bring the clock onto the alarm time, then maybe answer the buzzer
    task automatic ring_alarm();
        rtc_hour   = sb.hour;
        rtc_minute = (sb.minute == acsc_pkg::MINUTE_LAST) ? '0 : sb.minute + 1'b1;
        tick($urandom_range(1, 50));
        rtc_minute = sb.minute;
        repeat ($urandom_range(1, 3)) tick($urandom_range(1, 200));
        case ($urandom_range(0, 2))
            0: push_button(pick_hold(1'b0), 1'b1);
            1: begin
                push_button(pick_hold(1'b1), 1'b1);
                push_button(pick_hold(1'b0), 1'b1);
            end
            default: ;
        endcase
    endtask

    // Full edit: enter set mode, adjust hour and minute, leave, then hit the alarm
    task automatic edit_alarm();
        push_button(pick_hold(1'b1), 1'b1);
        knob_turn();
        push_button(pick_hold(1'b0), 1'b1);
        knob_turn();
        push_button(pick_hold(1'b0), 1'b1);
        ring_alarm();
    endtask

    task automatic quiet();
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) == 1) begin
                rtc_hour   = 5'($urandom_range(0, 23));
                rtc_minute = 6'($urandom_range(0, 59));
            end
            tick($urandom_range(0, 1500));
        end
    endtask

    // Arbitrary fields, out-of-range clock values and time jumps included
    task automatic noise();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 2) == 0)
                wall_ms = $urandom;
            btn_now    = 1'($urandom_range(0, 1));
            knob_code  = 2'($urandom_range(0, 3));
            rtc_hour   = 5'($urandom_range(0, 31));
            rtc_minute = 6'($urandom_range(0, 63));
            tick($urandom_range(0, 20));
        end
    endtask

    // Write all five registers while the block is idle
    task automatic write_config(input int unsigned step, input int unsigned lo,
                                input int unsigned hi, input int unsigned lp,
                                input int unsigned deb);
        logic [acsc_pkg::CFG_IDX_W-1:0] idx [5];
        logic [31:0]                    val [5];
        idx[0] = acsc_pkg::CFG_FREQ_STEP;     val[0] = step;
        idx[1] = acsc_pkg::CFG_FREQ_MIN;      val[1] = lo;
        idx[2] = acsc_pkg::CFG_FREQ_MAX;      val[2] = hi;
        idx[3] = acsc_pkg::CFG_LONG_PRESS_MS; val[3] = lp;
        idx[4] = acsc_pkg::CFG_DEBOUNCE_MS;   val[4] = deb;
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            forever begin
                @(posedge clk);
                if (cfg_ready === 1'b1)
                    break;
            end
            sb.write_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random scenarios under one setting, then drain all results
    task automatic run_phase(input int unsigned n, input bit idle, input bit squeeze);
        int unsigned stop;
        int          pick;
        bit          squeezed;
        squeezed     = 1'b0;
        stall_bursts = idle;
        stop         = sent + n;
        while (sent < stop) begin
            gaps_on = idle && ($urandom_range(0, 3) != 0);
            if (squeeze && !squeezed && sent + n / 2 >= stop) begin
                hold_request = 1'b1;
                squeezed     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)
                knob_turn();
            else if (pick < 45)
                push_button(pick_hold(1'($urandom_range(0, 1))), 1'b1);
            else if (pick < 60)
                edit_alarm();
            else if (pick < 75)
                ring_alarm();
            else if (pick < 87)
                quiet();
            else
                noise();
        end
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        now_ms       = '0;
        button_level = 1'b1;
        enc_a        = 1'b0;
        enc_b        = 1'b0;
        clock_hour   = '0;
        clock_minute = '0;
        cfg_valid    = 1'b0;
        cfg_index    = acsc_pkg::CFG_FREQ_STEP;
        cfg_data     = '0;
        wall_ms      = '0;
        btn_now      = 1'b1;
        knob_code    = 2'b00;
        rtc_hour     = '0;
        rtc_minute   = '0;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: knob both ways and an invalid jump, short and long presses
        tick(0);
        twist(4, 1'b1);
        twist(1, 1'b0);
        knob_code = ~knob_code;
        tick(5);
        push_button(1999, 1'b0);
        push_button(2000, 1'b0);
        // edit hour down, minute down through zero, long press ignored, leave
        twist(1, 1'b0);
        push_button(300, 1'b0);
        twist(1, 1'b0);
        push_button(5000, 1'b0);
        push_button(300, 1'b0);
        // alarm fires, long press ignored while ringing, short press silences
        rtc_hour   = 5'd11;
        rtc_minute = 6'd59;
        tick(10);
        push_button(2500, 1'b0);
        push_button(100, 1'b0);
        // out-of-range clock and a long press across the time wrap
        rtc_hour   = 5'd31;
        rtc_minute = 6'd63;
        wall_ms    = 32'hFFFF_FF00;
        push_button(2000, 1'b0);

        // Random phases, one per setting, extremes included
        run_phase(PHASE_TICKS, 1'b1, 1'b0);
        write_config(1000, 0, 4095, 0, 0);
        run_phase(PHASE_TICKS, 1'b1, 1'b0);
        write_config(1, 4095, 0, 65535, 1023);
        run_phase(PHASE_TICKS, 1'b1, 1'b0);
        write_config(37, 500, 3000, 300, 10);
        run_phase(PHASE_TICKS, 1'b1, 1'b1);
        write_config($urandom_range(1, 1000), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 3000),
                     $urandom_range(0, 200));
        run_phase(PHASE_TICKS, 1'b1, 1'b0);
        // last part runs back to back on both sides
        write_config(100, 200, 4000, 2000, 50);
        run_phase(PHASE_TICKS, 1'b0, 1'b0);

        // Let any stray result show up
        repeat (4) @(posedge clk);
        $display("Ran %0d ticks over six register settings, %0d results checked.",
                 sent, sb.checked);
        $display("Saw %0d set-mode entries, %0d alarms, %0d silenced, %0d long presses ignored.",
                 sb.n_enter, sb.n_alarm, sb.n_silence, sb.n_ignored);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/acsc_pkg.sv
hw/rtl/alarm_clock_setting_controller_unit.sv
test/alarm_clock_setting_controller_unit_tb.sv
